/* design/mmac_pkg.sv */
// Shared types and constants for the matrix multiply-accumulate unit.
package mmac_pkg;

   localparam int CMD_W     = 2;
   localparam int IDX_W     = 6;
   localparam int DATA_W    = 32;
   localparam int DIM_W     = 4;
   localparam int CNT_W     = 3;
   localparam int CSR_IDX_W = 3;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD_A  = 2'd0,
      CMD_LOAD_B  = 2'd1,
      CMD_LOAD_C  = 2'd2,
      CMD_COMPUTE = 2'd3
   } mmac_cmd_code_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_A_TRANSPOSED = 3'd0,
      CSR_B_TRANSPOSED = 3'd1,
      CSR_ROWS_M       = 3'd2,
      CSR_COLS_N       = 3'd3,
      CSR_INNER_K      = 3'd4,
      CSR_ALPHA        = 3'd5,
      CSR_BETA         = 3'd6
   } mmac_csr_type;

   typedef struct packed {
      logic [CMD_W-1:0]         cmd;
      logic [IDX_W-1:0]         index;
      logic signed [DATA_W-1:0] value;
   } mmac_req_type;

   typedef struct packed {
      logic [IDX_W-1:0]         out_index;
      logic signed [DATA_W-1:0] out_value;
      logic                     last;
   } mmac_rsp_type;

   // Configuration as seen by the controller and datapath (dimensions already clamped).
   typedef struct packed {
      logic                     a_transposed;
      logic                     b_transposed;
      logic [DIM_W-1:0]         rows_m;
      logic [DIM_W-1:0]         cols_n;
      logic [DIM_W-1:0]         inner_k;
      logic signed [DATA_W-1:0] alpha;
      logic signed [DATA_W-1:0] beta;
   } mmac_cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MAC,
      ST_DRAIN,
      ST_SC_LO,
      ST_SC_MID,
      ST_SC_HI,
      ST_SC_BETA,
      ST_SETTLE,
      ST_EMIT
   } mmac_state_type;

   // Steps of the scaling multiplier: three slices of the dot product times alpha,
   // then the prior C element times beta.
   typedef enum logic [1:0] {
      SC_LO   = 2'd0,
      SC_MID  = 2'd1,
      SC_HI   = 2'd2,
      SC_BETA = 2'd3
   } mmac_step_type;

   typedef struct packed {
      logic               load;
      logic               clear;
      logic               issue_mac;
      logic               c_read;
      logic               sc_issue;
      mmac_step_type      step;
      logic               emit;
      logic               last;
      logic [CNT_W-1:0]   row;
      logic [CNT_W-1:0]   col;
      logic [CNT_W-1:0]   dot;
   } mmac_dp_cmd_type;

   typedef struct packed {
      logic mac_busy;
      logic out_free;
   } mmac_dp_status_type;

endpackage

/* design/matrix_multiply_accumulate_unit.sv */
// Top level of the matrix multiply-accumulate unit: configuration registers and the two halves.
// Load transactions may follow back to back; a load is accepted even while a result
// transaction is still waiting at the output.
// A compute transaction that yields elements stalls the input until its last element has been
// emitted; each element is k serial multiply-accumulate steps through one read port per store,
// then four steps of the shared scaling multiplier, and its result is then registered for output.
// Reset is synchronous: it restores the configuration defaults and idles the sequencer; stores keep contents.
module matrix_multiply_accumulate_unit #(
   parameter int MAX_DIM   = 8,
   parameter int FRAC_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  mmac_pkg::mmac_req_type           req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output mmac_pkg::mmac_rsp_type           rsp_data,
   input  logic                             csr_we,
   input  logic [mmac_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [mmac_pkg::DATA_W-1:0]      csr_wdata
);
   import mmac_pkg::*;

   localparam logic [DIM_W-1:0] DIM_LIMIT = DIM_W'(MAX_DIM);

   // Configuration registers as written; dimensions are clamped on the way out.
   logic                     a_t_ff, a_t_in;
   logic                     b_t_ff, b_t_in;
   logic [DIM_W-1:0]         rows_ff, rows_in;
   logic [DIM_W-1:0]         cols_ff, cols_in;
   logic [DIM_W-1:0]         inner_ff, inner_in;
   logic signed [DATA_W-1:0] alpha_ff, alpha_in;
   logic signed [DATA_W-1:0] beta_ff, beta_in;

   mmac_cfg_type       cfg;
   mmac_dp_cmd_type    dp_cmd;
   mmac_dp_status_type dp_status;

   // Register decode. Writes to an index past the last register do nothing.
   always_comb begin
      a_t_in   = a_t_ff;
      b_t_in   = b_t_ff;
      rows_in  = rows_ff;
      cols_in  = cols_ff;
      inner_in = inner_ff;
      alpha_in = alpha_ff;
      beta_in  = beta_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_A_TRANSPOSED: a_t_in   = csr_wdata[0];
            CSR_B_TRANSPOSED: b_t_in   = csr_wdata[0];
            CSR_ROWS_M:       rows_in  = csr_wdata[DIM_W-1:0];
            CSR_COLS_N:       cols_in  = csr_wdata[DIM_W-1:0];
            CSR_INNER_K:      inner_in = csr_wdata[DIM_W-1:0];
            CSR_ALPHA:        alpha_in = signed'(csr_wdata);
            CSR_BETA:         beta_in  = signed'(csr_wdata);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_t_ff   <= 1'b0;
         b_t_ff   <= 1'b0;
         rows_ff  <= 4'd8;
         cols_ff  <= 4'd8;
         inner_ff <= 4'd8;
         alpha_ff <= 32'sd65536;
         beta_ff  <= 32'sd0;
      end else begin
         a_t_ff   <= a_t_in;
         b_t_ff   <= b_t_in;
         rows_ff  <= rows_in;
         cols_ff  <= cols_in;
         inner_ff <= inner_in;
         alpha_ff <= alpha_in;
         beta_ff  <= beta_in;
      end
   end

   // A dimension larger than the stores allow is treated as the largest one.
   always_comb begin
      cfg.a_transposed = a_t_ff;
      cfg.b_transposed = b_t_ff;
      cfg.rows_m       = (rows_ff > DIM_LIMIT) ? DIM_LIMIT : rows_ff;
      cfg.cols_n       = (cols_ff > DIM_LIMIT) ? DIM_LIMIT : cols_ff;
      cfg.inner_k      = (inner_ff > DIM_LIMIT) ? DIM_LIMIT : inner_ff;
      cfg.alpha        = alpha_ff;
      cfg.beta         = beta_ff;
   end

   mmac_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_valid),
      .req_cmd   (req_data.cmd),
      .req_stall (req_stall),
      .status    (dp_status),
      .cmd       (dp_cmd)
   );

   mmac_datapath #(
      .MAX_DIM   (MAX_DIM),
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd       (dp_cmd),
      .req_data  (req_data),
      .status    (dp_status),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

/* design/mmac_ctrl.sv */
// Sequencer for the matrix multiply-accumulate unit: walks rows, columns and the dot product.
module mmac_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  mmac_pkg::mmac_cfg_type       cfg,
   input  logic                         req_valid,
   input  logic [mmac_pkg::CMD_W-1:0]   req_cmd,
   output logic                         req_stall,
   input  mmac_pkg::mmac_dp_status_type status,
   output mmac_pkg::mmac_dp_cmd_type    cmd
);
   import mmac_pkg::*;

   mmac_state_type   state_ff, state_in;
   logic [CNT_W-1:0] row_ff, row_in;
   logic [CNT_W-1:0] col_ff, col_in;
   logic [CNT_W-1:0] dot_ff, dot_in;

   logic idle;
   logic start;
   logic k_zero;
   logic dot_last;
   logic row_last;
   logic col_last;
   logic elem_last;
   logic advance;

   assign idle      = (state_ff == ST_IDLE);
   assign req_stall = !idle;
   assign k_zero    = (cfg.inner_k == '0);
   assign start     = idle && req_valid && (req_cmd == CMD_COMPUTE) &&
                      (cfg.rows_m != '0) && (cfg.cols_n != '0);
   assign dot_last  = (DIM_W'(dot_ff) == cfg.inner_k - DIM_W'(1));
   assign row_last  = (DIM_W'(row_ff) == cfg.rows_m - DIM_W'(1));
   assign col_last  = (DIM_W'(col_ff) == cfg.cols_n - DIM_W'(1));
   assign elem_last = row_last && col_last;
   assign advance   = (state_ff == ST_EMIT) && status.out_free;

   always_comb begin : next_state
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) state_in = k_zero ? ST_DRAIN : ST_MAC;
         end
         ST_MAC: begin
            if (dot_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (!status.mac_busy) state_in = ST_SC_LO;
         end
         ST_SC_LO:   state_in = ST_SC_MID;
         ST_SC_MID:  state_in = ST_SC_HI;
         ST_SC_HI:   state_in = ST_SC_BETA;
         ST_SC_BETA: state_in = ST_SETTLE;
         ST_SETTLE:  state_in = ST_EMIT;
         ST_EMIT: begin
            if (status.out_free) begin
               if (elem_last) state_in = ST_IDLE;
               else state_in = k_zero ? ST_DRAIN : ST_MAC;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin : counters
      row_in = row_ff;
      col_in = col_ff;
      dot_in = dot_ff;
      if (start) begin
         row_in = '0;
         col_in = '0;
         dot_in = '0;
      end else if (state_ff == ST_MAC) begin
         dot_in = dot_last ? '0 : dot_ff + CNT_W'(1);
      end else if (advance && !elem_last) begin
         dot_in = '0;
         if (col_last) begin
            col_in = '0;
            row_in = row_ff + CNT_W'(1);
         end else begin
            col_in = col_ff + CNT_W'(1);
         end
      end
   end

   always_comb begin : outputs
      cmd           = '0;
      cmd.row       = row_ff;
      cmd.col       = col_ff;
      cmd.dot       = dot_ff;
      cmd.last      = elem_last;
      cmd.step      = SC_LO;
      cmd.load      = idle && req_valid && (req_cmd != CMD_COMPUTE);
      cmd.clear     = start || (advance && !elem_last);
      unique case (state_ff)
         ST_MAC:     cmd.issue_mac = 1'b1;
         ST_DRAIN:   cmd.c_read = 1'b1;
         ST_SC_LO: begin
            cmd.sc_issue = 1'b1;
            cmd.step     = SC_LO;
         end
         ST_SC_MID: begin
            cmd.sc_issue = 1'b1;
            cmd.step     = SC_MID;
         end
         ST_SC_HI: begin
            cmd.sc_issue = 1'b1;
            cmd.step     = SC_HI;
         end
         ST_SC_BETA: begin
            cmd.sc_issue = 1'b1;
            cmd.step     = SC_BETA;
         end
         ST_EMIT:    cmd.emit = status.out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         row_ff   <= '0;
         col_ff   <= '0;
         dot_ff   <= '0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         dot_ff   <= dot_in;
      end
   end

endmodule

/* design/mmac_datapath.sv */
// Datapath of the matrix multiply-accumulate unit: stores, MAC pipeline, scaling and output register.
module mmac_datapath #(
   parameter int MAX_DIM   = 8,
   parameter int FRAC_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  mmac_pkg::mmac_cfg_type       cfg,
   input  mmac_pkg::mmac_dp_cmd_type    cmd,
   input  mmac_pkg::mmac_req_type       req_data,
   output mmac_pkg::mmac_dp_status_type status,
   input  logic                         rsp_stall,
   output logic                         rsp_valid,
   output mmac_pkg::mmac_rsp_type       rsp_data
);
   import mmac_pkg::*;

   localparam int DEPTH  = MAX_DIM * MAX_DIM;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CALC_W = 2 * DIM_W;
   localparam int PROD_W = 2 * DATA_W;
   localparam int ACC_W  = PROD_W + 1 + $clog2(MAX_DIM);
   localparam int HI_W   = ACC_W - PROD_W;
   localparam int SCA_W  = DATA_W + 1;
   localparam int SP_W   = SCA_W + DATA_W;
   localparam int TOT_W  = ACC_W + DATA_W + 1;
   localparam int RND_SH = 2 * FRAC_BITS;
   localparam logic [TOT_W-1:0]  ROUND_CONST = TOT_W'(1) << (RND_SH - 1);
   localparam logic [DATA_W-1:0] SAT_MAX     = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic [DATA_W-1:0] SAT_MIN     = {1'b1, {(DATA_W-1){1'b0}}};

   // Stores
   logic signed [DATA_W-1:0] a_mem [DEPTH];
   logic signed [DATA_W-1:0] b_mem [DEPTH];
   logic signed [DATA_W-1:0] c_mem [DEPTH];

   logic signed [DATA_W-1:0] rd_a_ff, rd_b_ff, rd_c_ff;
   logic                     rd_vld_ff, prod_vld_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [SP_W-1:0]   sp_ff;
   logic                     sp_vld_ff;
   mmac_step_type            sp_step_ff;
   logic signed [TOT_W-1:0]  tot_ff;
   logic                     rsp_vld_ff;
   mmac_rsp_type             rsp_data_ff;

   logic [CALC_W-1:0] row_x, col_x, dot_x, m_x, n_x, k_x;
   logic [CALC_W-1:0] a_calc, b_calc, c_calc;
   logic [ADDR_W-1:0] a_addr, b_addr, c_addr, ld_addr;
   logic              ld_in_range;
   logic              a_we, b_we, c_we;
   logic [ADDR_W-1:0] c_waddr;
   logic [DATA_W-1:0] c_wdata;

   logic signed [SCA_W-1:0]  sc_a;
   logic signed [DATA_W-1:0] sc_b;
   logic signed [TOT_W-1:0]  sp_ext, sp_aligned;
   logic signed [TOT_W-1:0]  shifted;
   logic [TOT_W-DATA_W:0]    top_bits;
   logic [DATA_W-1:0]        sat_value;

   // Element addresses: row-major, with the transposed layouts swapping the roles.
   assign row_x  = CALC_W'(cmd.row);
   assign col_x  = CALC_W'(cmd.col);
   assign dot_x  = CALC_W'(cmd.dot);
   assign m_x    = CALC_W'(cfg.rows_m);
   assign n_x    = CALC_W'(cfg.cols_n);
   assign k_x    = CALC_W'(cfg.inner_k);
   assign a_calc = cfg.a_transposed ? dot_x * m_x + row_x : row_x * k_x + dot_x;
   assign b_calc = cfg.b_transposed ? col_x * k_x + dot_x : dot_x * n_x + col_x;
   assign c_calc = row_x * n_x + col_x;
   assign a_addr = a_calc[ADDR_W-1:0];
   assign b_addr = b_calc[ADDR_W-1:0];
   assign c_addr = c_calc[ADDR_W-1:0];

   // Loads beyond the store are dropped.
   assign ld_in_range = ({1'b0, req_data.index} < (IDX_W+1)'(DEPTH));
   assign ld_addr     = req_data.index[ADDR_W-1:0];
   assign a_we        = cmd.load && ld_in_range && (req_data.cmd == CMD_LOAD_A);
   assign b_we        = cmd.load && ld_in_range && (req_data.cmd == CMD_LOAD_B);
   assign c_we        = (cmd.load && ld_in_range && (req_data.cmd == CMD_LOAD_C)) || cmd.emit;
   assign c_waddr     = cmd.emit ? c_addr : ld_addr;
   assign c_wdata     = cmd.emit ? sat_value : req_data.value;

   always_ff @(posedge clock) begin
      if (a_we) a_mem[ld_addr] <= req_data.value;
      if (cmd.issue_mac) rd_a_ff <= a_mem[a_addr];
   end

   always_ff @(posedge clock) begin
      if (b_we) b_mem[ld_addr] <= req_data.value;
      if (cmd.issue_mac) rd_b_ff <= b_mem[b_addr];
   end

   always_ff @(posedge clock) begin
      if (c_we) c_mem[c_waddr] <= c_wdata;
      if (cmd.c_read) rd_c_ff <= c_mem[c_addr];
   end

   // Dot product: read, multiply, accumulate.
   always_ff @(posedge clock) begin
      prod_ff <= rd_a_ff * rd_b_ff;
      if (cmd.clear) acc_ff <= '0;
      else if (prod_vld_ff) acc_ff <= acc_ff + ACC_W'(prod_ff);
   end

   // Scaling multiplier operands. With beta zero the prior C element is not used.
   always_comb begin
      unique case (cmd.step)
         SC_LO:   sc_a = {1'b0, acc_ff[DATA_W-1:0]};
         SC_MID:  sc_a = {1'b0, acc_ff[PROD_W-1:DATA_W]};
         SC_HI:   sc_a = SCA_W'(signed'(acc_ff[ACC_W-1:PROD_W]));
         SC_BETA: sc_a = (cfg.beta == '0) ? '0 : SCA_W'(rd_c_ff);
         default: sc_a = '0;
      endcase
      sc_b = (cmd.step == SC_BETA) ? cfg.beta : cfg.alpha;
   end

   assign sp_ext = TOT_W'(sp_ff);

   always_comb begin
      unique case (sp_step_ff)
         SC_LO:   sp_aligned = sp_ext;
         SC_MID:  sp_aligned = sp_ext <<< DATA_W;
         SC_HI:   sp_aligned = sp_ext <<< PROD_W;
         SC_BETA: sp_aligned = sp_ext <<< FRAC_BITS;
         default: sp_aligned = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.sc_issue) begin
         sp_ff      <= sc_a * sc_b;
         sp_step_ff <= cmd.step;
      end
      if (cmd.clear) tot_ff <= ROUND_CONST;
      else if (sp_vld_ff) tot_ff <= tot_ff + sp_aligned;
   end

   // Round (constant preloaded into the total), shift down and saturate.
   assign shifted   = tot_ff >>> RND_SH;
   assign top_bits  = shifted[TOT_W-1:DATA_W-1];
   assign sat_value = ((&top_bits) || !(|top_bits)) ? shifted[DATA_W-1:0] :
                      (shifted[TOT_W-1] ? SAT_MIN : SAT_MAX);

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_data_ff.out_index <= c_calc[IDX_W-1:0];
         rsp_data_ff.out_value <= sat_value;
         rsp_data_ff.last      <= cmd.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff   <= 1'b0;
         prod_vld_ff <= 1'b0;
         sp_vld_ff   <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         rd_vld_ff   <= cmd.issue_mac;
         prod_vld_ff <= rd_vld_ff;
         sp_vld_ff   <= cmd.sc_issue;
         if (cmd.emit) rsp_vld_ff <= 1'b1;
         else if (!rsp_stall) rsp_vld_ff <= 1'b0;
      end
   end

   assign status.mac_busy = rd_vld_ff || prod_vld_ff;
   assign status.out_free = !rsp_vld_ff || !rsp_stall;
   assign rsp_valid       = rsp_vld_ff;
   assign rsp_data        = rsp_data_ff;

`ifndef ASSERT_OFF
   a_emit_settled: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !rd_vld_ff && !prod_vld_ff && !sp_vld_ff)
      else $error("result emitted while arithmetic still in flight");

   a_scale_after_mac: assert property (@(posedge clock) disable iff (reset)
      cmd.sc_issue |-> !rd_vld_ff && !prod_vld_ff)
      else $error("scaling started before the dot product drained");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !rsp_vld_ff || !rsp_stall)
      else $error("output register overwritten while stalled");

   a_load_exclusive: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> !cmd.issue_mac && !cmd.sc_issue && !cmd.emit)
      else $error("load overlaps a compute");
`endif

endmodule

/* tb/sv/matrix_multiply_accumulate_unit_tb.sv */
// Self-checking testbench for the matrix multiply-accumulate unit with a built-in scoreboard.
module matrix_multiply_accumulate_unit_tb;
   import mmac_pkg::*;

   localparam int MAX_DIM      = 8;
   localparam int FRAC         = 16;
   localparam int DEPTH        = MAX_DIM * MAX_DIM;
   // Settle margin that wait_idle adds after the last awaited element has come back.
   localparam int SETTLE_CYCLES = 32;
   localparam int CYCLE_LIMIT   = 600000;
   localparam int RANDOM_ITEMS  = 110;

   localparam logic [DATA_W-1:0] Q_ONE = 32'h0001_0000;
   localparam logic [DATA_W-1:0] Q_MAX = 32'h7FFF_FFFF;
   localparam logic [DATA_W-1:0] Q_MIN = 32'h8000_0000;

   // The scoreboard keeps its own copy of the three element stores and the configuration.
   // Every accepted compute transaction is expanded right away into the full list of C
   // elements it must produce, and each result transaction is checked against the oldest one.
   class gemm_scoreboard;
      logic signed [DATA_W-1:0] a_mem [DEPTH];
      logic signed [DATA_W-1:0] b_mem [DEPTH];
      logic signed [DATA_W-1:0] c_mem [DEPTH];
      bit                       a_trans;
      bit                       b_trans;
      logic [DIM_W-1:0]         rows_raw;
      logic [DIM_W-1:0]         cols_raw;
      logic [DIM_W-1:0]         inner_raw;
      logic signed [DATA_W-1:0] alpha_q;
      logic signed [DATA_W-1:0] beta_q;
      mmac_rsp_type             awaited_elements [$];
      int unsigned              mismatches;
      int unsigned              results_checked;

      function new();
         foreach (a_mem[i]) begin
            a_mem[i] = '0;
            b_mem[i] = '0;
            c_mem[i] = '0;
         end
         a_trans         = 1'b0;
         b_trans         = 1'b0;
         rows_raw        = 4'd8;
         cols_raw        = 4'd8;
         inner_raw       = 4'd8;
         alpha_q         = Q_ONE;
         beta_q          = '0;
         mismatches      = 0;
         results_checked = 0;
      endfunction

      task report(string msg);
         mismatches++;
         if (mismatches <= 40) begin
            $display("[%0t] MISMATCH: %s", $realtime, msg);
         end
      endtask

      function void write_register(mmac_csr_type idx, logic [DATA_W-1:0] data);
         case (idx)
            CSR_A_TRANSPOSED: a_trans   = data[0];
            CSR_B_TRANSPOSED: b_trans   = data[0];
            CSR_ROWS_M:       rows_raw  = data[DIM_W-1:0];
            CSR_COLS_N:       cols_raw  = data[DIM_W-1:0];
            CSR_INNER_K:      inner_raw = data[DIM_W-1:0];
            CSR_ALPHA:        alpha_q   = data;
            CSR_BETA:         beta_q    = data;
            default: ;
         endcase
      endfunction

      // One C element: exact dot product, exact alpha scaling, beta term aligned to the
      // same 48 fraction bits, then round half up and saturate to 32 bits.
      function logic signed [DATA_W-1:0] scaled_element(int unsigned i, int unsigned j,
                                                        int unsigned m, int unsigned n,
                                                        int unsigned k);
         logic signed [127:0] acc;
         logic signed [127:0] lhs;
         logic signed [127:0] rhs;
         acc = '0;
         for (int unsigned w = 0; w < k; w++) begin
            lhs = a_trans ? a_mem[w * m + i] : a_mem[i * k + w];
            rhs = b_trans ? b_mem[j * k + w] : b_mem[w * n + j];
            acc = acc + lhs * rhs;
         end
         rhs = alpha_q;
         acc = acc * rhs;
         // With beta at zero the prior C element is not read at all.
         if (beta_q != 0) begin
            lhs = beta_q;
            rhs = c_mem[i * n + j];
            acc = acc + ((lhs * rhs) <<< FRAC);
         end
         acc = acc + (128'sd1 <<< (2 * FRAC - 1));
         acc = acc >>> (2 * FRAC);
         if (acc > 128'sd2147483647) return Q_MAX;
         if (acc < -128'sd2147483648) return Q_MIN;
         return acc[DATA_W-1:0];
      endfunction

      function void note_request(mmac_req_type req);
         int unsigned        m;
         int unsigned        n;
         int unsigned        k;
         mmac_rsp_type       element;
         logic signed [31:0] result;
         case (req.cmd)
            CMD_LOAD_A: a_mem[req.index] = req.value;
            CMD_LOAD_B: b_mem[req.index] = req.value;
            CMD_LOAD_C: c_mem[req.index] = req.value;
            CMD_COMPUTE: begin
               // Dimensions above the store size saturate; a zero row or column count
               // gives no elements at all.
               m = (rows_raw > MAX_DIM) ? MAX_DIM : rows_raw;
               n = (cols_raw > MAX_DIM) ? MAX_DIM : cols_raw;
               k = (inner_raw > MAX_DIM) ? MAX_DIM : inner_raw;
               for (int unsigned i = 0; i < m; i++) begin
                  for (int unsigned j = 0; j < n; j++) begin
                     result              = scaled_element(i, j, m, n, k);
                     c_mem[i * n + j]    = result;
                     element.out_index   = IDX_W'(i * n + j);
                     element.out_value   = result;
                     element.last        = (i == m - 1) && (j == n - 1);
                     awaited_elements.push_back(element);
                  end
               end
            end
            default: ;
         endcase
      endfunction

      task check_result(mmac_rsp_type got);
         mmac_rsp_type want;
         results_checked++;
         if (awaited_elements.size() == 0) begin
            report($sformatf("result for C[%0d] arrived with no element awaited",
                             got.out_index));
            return;
         end
         want = awaited_elements.pop_front();
         if (got.out_index !== want.out_index) begin
            report($sformatf("out_index %0d, awaited %0d", got.out_index, want.out_index));
         end
         if (got.out_value !== want.out_value) begin
            report($sformatf("C[%0d] out_value %h, awaited %h", want.out_index,
                             got.out_value, want.out_value));
         end
         if (got.last !== want.last) begin
            report($sformatf("C[%0d] last %b, awaited %b", want.out_index,
                             got.last, want.last));
         end
      endtask
   endclass

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   mmac_req_type         req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   mmac_rsp_type         rsp_data;
   logic                 csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [DATA_W-1:0]    csr_wdata = '0;

   gemm_scoreboard sb;

   // Stimulus bookkeeping. A store entry that was never loaded must never be read by a
   // compute, so the sender tracks which entries hold data and fills the rest first.
   bit          filled [3][DEPTH];
   int unsigned dim_m;
   int unsigned dim_n;
   int unsigned dim_k;
   bit          beta_nonzero;
   int unsigned burst_left;
   int unsigned items_sent;
   int unsigned settings_applied;
   int unsigned cycle_count = 0;
   int unsigned stall_left  = 0;
   int unsigned stall_mode  = 0;

   matrix_multiply_accumulate_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #10 clock = ~clock;

   // The watchdog ends a run that hangs; the slowest correct run is far below this limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Verification failed");
         $finish;
      end
   end

   // The receiver switches at random between four stall behaviors: never stalled,
   // lightly stalled, stalled half the time, or stalled almost always.
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_left <= $urandom_range(5, 60);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 1) == 0);
         default: rsp_stall <= ($urandom_range(0, 7) != 0);
      endcase
   end

   // Both channels are observed at the clock edge, where inputs and outputs still hold
   // their values from before the edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            sb.note_request(req_data);
         end
         if (rsp_valid && !rsp_stall) begin
            sb.check_result(rsp_data);
         end
      end
   end

   // Mostly moderate values so that products stay in range, with the extremes and fully
   // random words mixed in so that saturation and every bit get exercised.
   function automatic logic [DATA_W-1:0] random_fixed();
      logic [DATA_W-1:0] r;
      r = $urandom();
      case ($urandom_range(0, 9))
         0: return Q_MAX;
         1: return Q_MIN;
         2: return r;
         3: return $urandom_range(0, 2) - 1;
         default: return {{13{r[31]}}, r[18:0]};
      endcase
   endfunction

   function automatic logic [DIM_W-1:0] random_dim();
      case ($urandom_range(0, 19))
         0: return '0;
         1: return DIM_W'($urandom_range(MAX_DIM + 1, 15));
         2: return DIM_W'(MAX_DIM);
         default: return DIM_W'($urandom_range(1, 4));
      endcase
   endfunction

   // The sender works in bursts; between bursts it drops valid for a random gap. Valid stays
   // high from one transaction to the next within a burst.
   task automatic send_item(mmac_req_type item);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 10);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   task automatic load_element(mmac_cmd_code_type cmd, int unsigned idx,
                               logic [DATA_W-1:0] data);
      mmac_req_type item;
      item.cmd   = cmd;
      item.index = IDX_W'(idx);
      item.value = data;
      send_item(item);
      filled[cmd][idx] = 1'b1;
   endtask

   // A compute ignores index and value, so both carry random bits.
   task automatic start_compute();
      mmac_req_type item;
      item.cmd   = CMD_COMPUTE;
      item.index = IDX_W'($urandom());
      item.value = $urandom();
      send_item(item);
   endtask

   // Loads every entry that the next compute will read and that holds no data yet.
   task automatic fill_operands();
      if (dim_m == 0 || dim_n == 0) return;
      for (int unsigned i = 0; i < dim_m * dim_k; i++) begin
         if (!filled[CMD_LOAD_A][i]) load_element(CMD_LOAD_A, i, random_fixed());
      end
      for (int unsigned i = 0; i < dim_k * dim_n; i++) begin
         if (!filled[CMD_LOAD_B][i]) load_element(CMD_LOAD_B, i, random_fixed());
      end
      if (beta_nonzero) begin
         for (int unsigned i = 0; i < dim_m * dim_n; i++) begin
            if (!filled[CMD_LOAD_C][i]) load_element(CMD_LOAD_C, i, random_fixed());
         end
      end
   endtask

   // Drops valid and waits until every awaited element has come back, then lets the
   // block settle. The first edge makes sure the last accepted compute has been noted.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.awaited_elements.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic put_register(mmac_csr_type idx, logic [DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      sb.write_register(idx, data);
      @(posedge clock);
   endtask

   // Registers are only written with the block idle. All seven are written every time.
   task automatic apply_setting(bit a_t, bit b_t, logic [DIM_W-1:0] m, logic [DIM_W-1:0] n,
                                logic [DIM_W-1:0] k, logic [DATA_W-1:0] alpha,
                                logic [DATA_W-1:0] beta);
      wait_idle();
      put_register(CSR_A_TRANSPOSED, DATA_W'(a_t));
      put_register(CSR_B_TRANSPOSED, DATA_W'(b_t));
      put_register(CSR_ROWS_M, DATA_W'(m));
      put_register(CSR_COLS_N, DATA_W'(n));
      put_register(CSR_INNER_K, DATA_W'(k));
      put_register(CSR_ALPHA, alpha);
      put_register(CSR_BETA, beta);
      csr_we <= 1'b0;
      dim_m        = (m > MAX_DIM) ? MAX_DIM : m;
      dim_n        = (n > MAX_DIM) ? MAX_DIM : n;
      dim_k        = (k > MAX_DIM) ? MAX_DIM : k;
      beta_nonzero = (beta != 0);
      settings_applied++;
   endtask

   // A well-formed sequence: a few loads anywhere in the stores, a few into the region the
   // compute reads, whatever is still missing there, then the compute itself.
   task automatic operand_sequence();
      mmac_cmd_code_type cmd;
      int unsigned       span;
      for (int r = $urandom_range(0, 3); r > 0; r--) begin
         load_element(mmac_cmd_code_type'($urandom_range(CMD_LOAD_A, CMD_LOAD_C)),
                      $urandom_range(0, DEPTH - 1), random_fixed());
      end
      for (int r = $urandom_range(0, 4); r > 0; r--) begin
         cmd  = mmac_cmd_code_type'($urandom_range(CMD_LOAD_A, CMD_LOAD_C));
         span = (cmd == CMD_LOAD_A) ? dim_m * dim_k :
                (cmd == CMD_LOAD_B) ? dim_k * dim_n : dim_m * dim_n;
         if (span != 0) load_element(cmd, $urandom_range(0, span - 1), random_fixed());
      end
      fill_operands();
      start_compute();
   endtask

   initial begin
      int unsigned random_start;
      int unsigned phase;
      sb               = new();
      burst_left       = 0;
      items_sent       = 0;
      settings_applied = 0;
      phase            = 0;
      foreach (filled[c, i]) filled[c][i] = 1'b0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Single element: saturation at both ends, then rounding of an exact half upward
      // for a positive and a negative product.
      apply_setting(1'b0, 1'b0, 4'd1, 4'd1, 4'd1, Q_ONE, '0);
      load_element(CMD_LOAD_A, 0, Q_MAX);
      load_element(CMD_LOAD_B, 0, Q_MAX);
      start_compute();
      load_element(CMD_LOAD_A, 0, Q_MIN);
      start_compute();
      load_element(CMD_LOAD_A, 0, 32'h0000_0001);
      load_element(CMD_LOAD_B, 0, 32'h0000_8000);
      start_compute();
      load_element(CMD_LOAD_A, 0, 32'hFFFF_FFFF);
      start_compute();

      // Empty inner dimension: the result is the beta term alone, with extreme C values
      // and extreme alpha and beta.
      apply_setting(1'b0, 1'b0, 4'd2, 4'd2, 4'd0, Q_MIN, Q_MAX);
      load_element(CMD_LOAD_C, 0, Q_MAX);
      load_element(CMD_LOAD_C, 1, Q_MIN);
      load_element(CMD_LOAD_C, 2, Q_ONE);
      load_element(CMD_LOAD_C, 3, 32'hFFFF_FFFF);
      start_compute();

      // Both operands transposed with beta at one; the second compute accumulates onto
      // the results that the first wrote back into C.
      apply_setting(1'b1, 1'b1, 4'd2, 4'd3, 4'd2, Q_ONE, Q_ONE);
      fill_operands();
      start_compute();
      start_compute();

      // Zero rows and zero columns give no result transactions.
      apply_setting(1'b0, 1'b0, 4'd0, 4'd3, 4'd2, Q_ONE, '0);
      start_compute();
      apply_setting(1'b0, 1'b1, 4'd3, 4'd0, 4'd2, '0, Q_MIN);
      start_compute();

      // A row count above the store size clamps to the maximum; the top entry of every
      // store is loaded as well.
      apply_setting(1'b1, 1'b0, 4'd15, 4'd1, 4'd1, Q_MAX, '0);
      load_element(CMD_LOAD_A, DEPTH - 1, random_fixed());
      load_element(CMD_LOAD_B, DEPTH - 1, random_fixed());
      load_element(CMD_LOAD_C, DEPTH - 1, random_fixed());
      fill_operands();
      start_compute();

      // Random part: a new setting per phase, then one to three compute sequences.
      random_start = items_sent;
      while (items_sent - random_start < RANDOM_ITEMS) begin
         apply_setting($urandom_range(0, 1), $urandom_range(0, 1), random_dim(),
                       random_dim(), random_dim(), random_fixed(),
                       ($urandom_range(0, 2) == 0) ? '0 : random_fixed());
         for (int s = $urandom_range(1, 3); s > 0; s--) begin
            operand_sequence();
            // Once, hold the input back until every awaited element has come out.
            if (phase == 2) wait_idle();
         end
         phase++;
      end

      wait_idle();
      if (sb.awaited_elements.size() != 0) begin
         sb.report($sformatf("%0d awaited elements never arrived",
                             sb.awaited_elements.size()));
      end
      $display("Run covered %0d input transactions under %0d register settings,",
               items_sent, settings_applied);
      $display("with %0d result transactions checked and %0d mismatches.",
               sb.results_checked, sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

/* sim.f */
design/mmac_pkg.sv
design/mmac_ctrl.sv
design/mmac_datapath.sv
design/matrix_multiply_accumulate_unit.sv
tb/sv/matrix_multiply_accumulate_unit_tb.sv
